// File: rtl/core/pid_trace_filter_table_macros.svh
// Assertion macros for the process-ID trace filter.
// The including scope must provide clk and arst_n.
`ifndef PID_TRACE_FILTER_TABLE_MACROS_SVH
`define PID_TRACE_FILTER_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PTF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PTF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/ptf_pkg.sv
// Shared types and constants of the process-ID trace filter.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ptf_pkg;

	// Default sizes and the fixed port width of the process ID.
	localparam int LIST_DEPTH_DEF = 32;
	localparam int ID_BITS_DEF    = 22;
	localparam int PROC_ID_W      = 22;
	localparam int CMD_W          = 2;
	localparam int STATUS_W       = 2;

	// Request kinds.
	typedef enum logic [CMD_W-1:0] {
		CMD_ENABLE  = 2'd0,
		CMD_DISABLE = 2'd1,
		CMD_CHECK   = 2'd2
	} cmd_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_ACT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the accepted request
		logic cmp;     // register the match vectors
		logic commit;  // update the lists and load the result
		logic take;    // the pending result leaves this cycle
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic res_valid;
	} dp_sts_t;

endpackage

// File: rtl/core/ptf_ctrl.sv
// Controller of the process-ID trace filter: sequences compare and commit.
// Depends on ptf_pkg.
`timescale 1ns / 1ps

module ptf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              out_stall,
	input  ptf_pkg::dp_sts_t  sts,
	output ptf_pkg::dp_cmd_t  cmd_o
);

	ptf_pkg::state_t state_q;
	ptf_pkg::state_t state_nxt;
	logic            accept;
	logic            slot_free;

	// A new request is taken only between operations.
	assign in_stall  = (state_q != ptf_pkg::S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !sts.res_valid || !out_stall;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ptf_pkg::S_IDLE: begin
				if (accept) state_nxt = ptf_pkg::S_CMP;
			end
			ptf_pkg::S_CMP: begin
				state_nxt = ptf_pkg::S_ACT;
			end
			ptf_pkg::S_ACT: begin
				if (slot_free) state_nxt = ptf_pkg::S_IDLE;
			end
			default: begin
				state_nxt = ptf_pkg::S_IDLE;
			end
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd_o        = '0;
		cmd_o.take   = sts.res_valid && !out_stall;
		case (state_q)
			ptf_pkg::S_IDLE: begin
				cmd_o.load = accept;
			end
			ptf_pkg::S_CMP: begin
				cmd_o.cmp = 1'b1;
			end
			ptf_pkg::S_ACT: begin
				cmd_o.commit = slot_free;
			end
			default: begin
				cmd_o.load = 1'b0;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptf_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// File: rtl/core/ptf_dpath.sv
// Datapath of the process-ID trace filter: the two ID lists, their match
// lanes, the compaction shift and the result register. Depends on ptf_pkg.
`timescale 1ns / 1ps

module ptf_dpath #(
	parameter int LIST_DEPTH = ptf_pkg::LIST_DEPTH_DEF,
	parameter int ID_BITS    = ptf_pkg::ID_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ptf_pkg::dp_cmd_t              cmd_i,
	output ptf_pkg::dp_sts_t              sts,
	input  logic [ptf_pkg::CMD_W-1:0]     cmd,
	input  logic                          all_ids,
	input  logic [ptf_pkg::PROC_ID_W-1:0] proc_id,
	output logic [ptf_pkg::STATUS_W-1:0]  status,
	output logic                          traced
);

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int IDX_W = $clog2(LIST_DEPTH);

	// Captured request.
	logic [ptf_pkg::CMD_W-1:0] cmd_q;
	logic                      all_q;
	logic [ID_BITS-1:0]        id_q;

	// List storage and state.
	logic [ID_BITS-1:0] en_ids_q  [LIST_DEPTH];
	logic [ID_BITS-1:0] dis_ids_q [LIST_DEPTH];
	logic [CNT_W-1:0]   en_cnt_q;
	logic [CNT_W-1:0]   dis_cnt_q;
	logic               trace_all_q;

	// Match vectors, registered after the compare cycle.
	logic [LIST_DEPTH-1:0] en_hit;
	logic [LIST_DEPTH-1:0] dis_hit;
	logic [LIST_DEPTH-1:0] en_hit_s1;
	logic [LIST_DEPTH-1:0] dis_hit_s1;
	logic [LIST_DEPTH-1:0] en_shift;
	logic [LIST_DEPTH-1:0] dis_shift;

	// Commit decisions.
	logic                        en_any;
	logic                        dis_any;
	logic                        en_full;
	logic                        dis_full;
	logic                        en_rm;
	logic                        dis_rm;
	logic                        en_add;
	logic                        dis_add;
	logic                        set_all;
	logic                        clr_all;
	logic [ptf_pkg::STATUS_W-1:0] status_nxt;
	logic                        traced_nxt;

	// Result register.
	logic                         res_valid_q;
	logic [ptf_pkg::STATUS_W-1:0] status_q;
	logic                         traced_q;

	// Request capture; the ID is cut or widened to the stored width.
	always_ff @(posedge clk) begin
		if (cmd_i.load) begin
			cmd_q <= cmd;
			all_q <= all_ids;
			id_q  <= ID_BITS'(proc_id);
		end
	end

	// One comparator per entry; only entries below the count take part.
	always_comb begin
		for (int i = 0; i < LIST_DEPTH; i++) begin
			en_hit[i]  = (CNT_W'(i) < en_cnt_q)  && (en_ids_q[i]  == id_q);
			dis_hit[i] = (CNT_W'(i) < dis_cnt_q) && (dis_ids_q[i] == id_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.cmp) begin
			en_hit_s1  <= en_hit;
			dis_hit_s1 <= dis_hit;
		end
	end

	// Entries at and above the hit move down by one; IDs are unique, so
	// the hit vector has at most one bit set and a prefix OR marks them.
	always_comb begin
		en_shift  = en_hit_s1;
		dis_shift = dis_hit_s1;
		for (int k = 1; k < LIST_DEPTH; k = k * 2) begin
			en_shift  = en_shift  | (en_shift  << k);
			dis_shift = dis_shift | (dis_shift << k);
		end
	end

	assign en_any   = |en_hit_s1;
	assign dis_any  = |dis_hit_s1;
	assign en_full  = (en_cnt_q  == CNT_W'(LIST_DEPTH));
	assign dis_full = (dis_cnt_q == CNT_W'(LIST_DEPTH));

	// Decide the list updates and the result of the request.
	always_comb begin
		en_rm      = 1'b0;
		dis_rm     = 1'b0;
		en_add     = 1'b0;
		dis_add    = 1'b0;
		set_all    = 1'b0;
		clr_all    = 1'b0;
		status_nxt = ptf_pkg::ST_OK;
		traced_nxt = 1'b0;
		case (cmd_q)
			ptf_pkg::CMD_ENABLE: begin
				if (all_q) begin
					set_all = 1'b1;
				end else if (!trace_all_q) begin
					// The removal stands even if the append fails.
					dis_rm = dis_any;
					if (en_full) begin
						status_nxt = ptf_pkg::ST_FULL;
					end else if (en_any) begin
						status_nxt = ptf_pkg::ST_INVALID;
					end else begin
						en_add = 1'b1;
					end
				end
			end
			ptf_pkg::CMD_DISABLE: begin
				if (all_q) begin
					clr_all = 1'b1;
				end else if ((en_cnt_q == '0) || en_any) begin
					en_rm = en_any;
					if (dis_full) begin
						status_nxt = ptf_pkg::ST_FULL;
					end else if (dis_any) begin
						status_nxt = ptf_pkg::ST_INVALID;
					end else begin
						dis_add = 1'b1;
					end
				end else begin
					status_nxt = ptf_pkg::ST_INVALID;
				end
			end
			ptf_pkg::CMD_CHECK: begin
				if (all_q) begin
					traced_nxt = trace_all_q;
				end else if (trace_all_q) begin
					traced_nxt = !dis_any;
				end else begin
					traced_nxt = !dis_any && en_any;
				end
			end
			default: begin
				status_nxt = ptf_pkg::ST_INVALID;
			end
		endcase
	end

	// Counts and the trace-all flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_cnt_q    <= '0;
			dis_cnt_q   <= '0;
			trace_all_q <= 1'b0;
		end else if (cmd_i.commit) begin
			if (set_all || clr_all) begin
				en_cnt_q    <= '0;
				dis_cnt_q   <= '0;
				trace_all_q <= set_all;
			end else begin
				if (en_rm) begin
					en_cnt_q <= en_cnt_q - 1'b1;
				end else if (en_add) begin
					en_cnt_q <= en_cnt_q + 1'b1;
				end
				if (dis_rm) begin
					dis_cnt_q <= dis_cnt_q - 1'b1;
				end else if (dis_add) begin
					dis_cnt_q <= dis_cnt_q + 1'b1;
				end
			end
		end
	end

	// List entries: compaction shift on removal, write at the count on append.
	always_ff @(posedge clk) begin
		if (cmd_i.commit) begin
			for (int i = 0; i < LIST_DEPTH; i++) begin
				if (en_add && (en_cnt_q[IDX_W-1:0] == IDX_W'(i))) begin
					en_ids_q[i] <= id_q;
				end else if (en_rm && en_shift[i] && (i < LIST_DEPTH - 1)) begin
					en_ids_q[i] <= en_ids_q[(i + 1) % LIST_DEPTH];
				end
				if (dis_add && (dis_cnt_q[IDX_W-1:0] == IDX_W'(i))) begin
					dis_ids_q[i] <= id_q;
				end else if (dis_rm && dis_shift[i] && (i < LIST_DEPTH - 1)) begin
					dis_ids_q[i] <= dis_ids_q[(i + 1) % LIST_DEPTH];
				end
			end
		end
	end

	// Result register; it holds while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd_i.commit) begin
			res_valid_q <= 1'b1;
		end else if (cmd_i.take) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.commit) begin
			status_q <= status_nxt;
			traced_q <= traced_nxt;
		end
	end

	assign sts.res_valid = res_valid_q;
	assign status        = status_q;
	assign traced        = traced_q;

endmodule

// File: rtl/core/pid_trace_filter_table.sv
// Top level of the process-ID trace filter: controller plus datapath.
// Depends on ptf_pkg, ptf_ctrl, ptf_dpath and the assertion macro header.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------
//   in      | in_valid, in_stall   | cmd, all_ids, proc_id
//   out     | out_valid, out_stall | status, traced
//
// A request is accepted in S_IDLE, matched against both lists in S_CMP,
// and committed in S_ACT, when the result register is loaded.
// A new request is taken the cycle after commit; only one is in flight.
// Commit waits while an earlier result is still held by out_stall.
// After reset both lists are empty and trace-all is off; no clearing pass.
`timescale 1ns / 1ps
`include "pid_trace_filter_table_macros.svh"

module pid_trace_filter_table #(
	parameter int LIST_DEPTH = ptf_pkg::LIST_DEPTH_DEF,
	parameter int ID_BITS    = ptf_pkg::ID_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ptf_pkg::CMD_W-1:0]     cmd,
	input  logic                          all_ids,
	input  logic [ptf_pkg::PROC_ID_W-1:0] proc_id,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ptf_pkg::STATUS_W-1:0]  status,
	output logic                          traced
);

	ptf_pkg::dp_cmd_t dp_cmd;
	ptf_pkg::dp_sts_t dp_sts;

	// Sequencer.
	ptf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.sts       (dp_sts),
		.cmd_o     (dp_cmd)
	);

	// Lists, match lanes and result register.
	ptf_dpath #(
		.LIST_DEPTH (LIST_DEPTH),
		.ID_BITS    (ID_BITS)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_i   (dp_cmd),
		.sts     (dp_sts),
		.cmd     (cmd),
		.all_ids (all_ids),
		.proc_id (proc_id),
		.status  (status),
		.traced  (traced)
	);

	assign out_valid = dp_sts.res_valid;

	// An accepted request keeps the input side busy while it is processed.
	`PTF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after accept")

	// A result only appears at the end of processing a request.
	`PTF_ASSERT_NOW(a_result_from_request, $rose(out_valid), $past(in_stall), "result without request")

	// Only a successful check reports a traced ID.
	`PTF_ASSERT_NOW(a_traced_ok, out_valid && traced, status == ptf_pkg::ST_OK, "traced with bad status")

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the process-ID trace filter table.
// Depends on ptf_pkg and the pid_trace_filter_table RTL; a built-in predictor
// tracks both ID lists and the trace-all flag and checks each response.
`timescale 1ns / 1ps

module tb_top;
	import ptf_pkg::*;

	localparam int DEPTH      = LIST_DEPTH_DEF;
	localparam int EN_LIST    = 0;
	localparam int DIS_LIST   = 1;
	localparam int REQ_TARGET = 1900;
	localparam int POOL_MAX   = 48;
	localparam bit [PROC_ID_W-1:0] ID_MASK = PROC_ID_W'((64'd1 << ID_BITS_DEF) - 64'd1);
	localparam bit [PROC_ID_W-1:0] ID_TOP  = {PROC_ID_W{1'b1}};

	typedef struct {
		cmd_t                 cmd;
		bit                   all_ids;
		bit [PROC_ID_W-1:0]   proc_id;
	} request_t;

	typedef struct {
		status_t status;
		bit      traced;
	} verdict_t;

	// Clock, reset and DUT ports; the driven ones are known from time zero.
	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	logic [CMD_W-1:0]       cmd       = '0;
	logic                   all_ids   = 1'b0;
	logic [PROC_ID_W-1:0]   proc_id   = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [STATUS_W-1:0]    status;
	logic                   traced;

	// Shadow state of the filter.
	bit [PROC_ID_W-1:0] shadow_ids [2][DEPTH];
	int                 shadow_cnt [2];
	bit                 shadow_all;

	request_t           request_q[$];
	verdict_t           verdict_q[$];
	verdict_t           got;
	int                 n_accepted = 0;
	int                 n_bad      = 0;
	int                 idle_pct   = 0;
	int                 stall_pct  = 0;
	bit                 hold_in    = 1'b0;
	bit                 drained    = 1'b0;
	bit [PROC_ID_W-1:0] id_pool [POOL_MAX];

	pid_trace_filter_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.all_ids   (all_ids),
		.proc_id   (proc_id),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.traced    (traced)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Position of an ID in one shadow list, or -1 when it is absent.
	function automatic int list_pos(int l, bit [PROC_ID_W-1:0] id);
		for (int i = 0; i < shadow_cnt[l]; i++) begin
			if (shadow_ids[l][i] == id) begin
				return i;
			end
		end
		return -1;
	endfunction

	// Removes an ID and closes the gap; returns whether it was there.
	function automatic bit list_drop(int l, bit [PROC_ID_W-1:0] id);
		int p;
		p = list_pos(l, id);
		if (p < 0) begin
			return 1'b0;
		end
		for (int i = p; i + 1 < shadow_cnt[l]; i++) begin
			shadow_ids[l][i] = shadow_ids[l][i + 1];
		end
		shadow_cnt[l]--;
		return 1'b1;
	endfunction

	function automatic status_t list_append(int l, bit [PROC_ID_W-1:0] id);
		if (shadow_cnt[l] >= DEPTH) begin
			return ST_FULL;
		end
		if (list_pos(l, id) >= 0) begin
			return ST_INVALID;
		end
		shadow_ids[l][shadow_cnt[l]] = id;
		shadow_cnt[l]++;
		return ST_OK;
	endfunction

	// Applies one request to the shadow state and returns the response it must give.
	function automatic verdict_t trace_verdict(request_t r);
		verdict_t           v;
		bit [PROC_ID_W-1:0] id;
		bit                 in_dis;
		bit                 in_en;
		v.status = ST_OK;
		v.traced = 1'b0;
		id = r.proc_id & ID_MASK;
		case (r.cmd)
			CMD_ENABLE: begin
				if (r.all_ids) begin
					shadow_all = 1'b1;
					shadow_cnt[EN_LIST] = 0;
					shadow_cnt[DIS_LIST] = 0;
				end else if (!shadow_all) begin
					// The removal from the disabled list stands even if the append fails.
					void'(list_drop(DIS_LIST, id));
					v.status = list_append(EN_LIST, id);
				end
			end
			CMD_DISABLE: begin
				if (r.all_ids) begin
					shadow_all = 1'b0;
					shadow_cnt[EN_LIST] = 0;
					shadow_cnt[DIS_LIST] = 0;
				end else if (shadow_cnt[EN_LIST] == 0 || list_drop(EN_LIST, id)) begin
					v.status = list_append(DIS_LIST, id);
				end else begin
					v.status = ST_INVALID;
				end
			end
			CMD_CHECK: begin
				if (r.all_ids) begin
					v.traced = shadow_all;
				end else begin
					in_dis = list_pos(DIS_LIST, id) >= 0;
					in_en  = list_pos(EN_LIST, id) >= 0;
					v.traced = shadow_all ? !in_dis : (!in_dis && in_en);
				end
			end
			default: begin
				v.status = ST_INVALID;
			end
		endcase
		return v;
	endfunction

	task automatic push_req(cmd_t c, bit a, bit [PROC_ID_W-1:0] id);
		request_t r;
		r.cmd = c;
		r.all_ids = a;
		r.proc_id = id;
		request_q.push_back(r);
	endtask

	// Random ID with the extremes turning up often.
	function automatic bit [PROC_ID_W-1:0] pick_id();
		case ($urandom_range(9))
			0: return '0;
			1: return ID_TOP;
			2: return PROC_ID_W'($urandom_range(15));
			default: return PROC_ID_W'($urandom);
		endcase
	endfunction

	function automatic cmd_t pick_cmd();
		case ($urandom_range(2))
			0: return CMD_ENABLE;
			1: return CMD_DISABLE;
			default: return CMD_CHECK;
		endcase
	endfunction

	// Fills the request queue: directed corner cases, then random sequences.
	task automatic build_requests();
		int kind;
		int n;
		int pool_n;
		push_req(CMD_CHECK, 1'b1, '0);
		push_req(CMD_CHECK, 1'b0, '0);
		push_req(CMD_DISABLE, 1'b0, '0);      // enabled list empty: direct add
		push_req(CMD_DISABLE, 1'b0, '0);      // duplicate
		push_req(CMD_ENABLE, 1'b0, '0);       // moves from disabled to enabled
		push_req(CMD_ENABLE, 1'b0, '0);       // duplicate
		push_req(CMD_ENABLE, 1'b0, ID_TOP);
		push_req(CMD_CHECK, 1'b0, '0);
		push_req(CMD_CHECK, 1'b0, ID_TOP);
		push_req(CMD_DISABLE, 1'b0, 22'd5);   // unknown while enabled list is in use
		push_req(CMD_DISABLE, 1'b0, ID_TOP);
		push_req(CMD_CHECK, 1'b0, ID_TOP);
		push_req(CMD_ENABLE, 1'b1, '0);
		push_req(CMD_ENABLE, 1'b0, 22'd9);    // trace-all on: no change
		push_req(CMD_CHECK, 1'b0, 22'd9);
		push_req(CMD_DISABLE, 1'b0, 22'd9);
		push_req(CMD_CHECK, 1'b0, 22'd9);
		push_req(CMD_CHECK, 1'b1, '0);
		push_req(CMD_DISABLE, 1'b1, '0);
		push_req(CMD_CHECK, 1'b1, '0);
		push_req(CMD_CHECK, 1'b0, 22'd9);
		push_req(CMD_ENABLE, 1'b1, ID_TOP);
		push_req(CMD_DISABLE, 1'b1, ID_TOP);

		while (request_q.size() < REQ_TARGET) begin
			kind = $urandom_range(9);
			pool_n = (kind <= 1) ? POOL_MAX : $urandom_range(4, 40);
			for (int i = 0; i < pool_n; i++) begin
				id_pool[i] = pick_id();
			end
			case (kind)
				// Fill the enabled list past its depth, then poke at it.
				0: begin
					push_req(CMD_DISABLE, 1'b1, pick_id());
					n = $urandom_range(34, 40);
					for (int i = 0; i < n; i++) begin
						push_req(CMD_ENABLE, 1'b0, id_pool[i]);
					end
					for (int i = 0; i < 8; i++) begin
						push_req(pick_cmd(), 1'b0, id_pool[$urandom_range(pool_n - 1)]);
					end
				end
				// Fill the disabled list directly while the enabled list is empty.
				1: begin
					push_req(CMD_DISABLE, 1'b1, pick_id());
					n = $urandom_range(34, 40);
					for (int i = 0; i < n; i++) begin
						push_req(CMD_DISABLE, 1'b0, id_pool[i]);
					end
					for (int i = 0; i < 8; i++) begin
						push_req(pick_cmd(), 1'b0, id_pool[$urandom_range(pool_n - 1)]);
					end
				end
				// Trace-all with exceptions carved out.
				2: begin
					push_req(CMD_ENABLE, 1'b1, pick_id());
					for (int i = 0; i < 16; i++) begin
						push_req(pick_cmd(), $urandom_range(29) == 0,
							id_pool[$urandom_range(pool_n - 1)]);
					end
				end
				// General mix over a small ID pool.
				default: begin
					for (int i = 0; i < 20; i++) begin
						push_req(pick_cmd(), $urandom_range(19) == 0,
							($urandom_range(9) == 0) ? PROC_ID_W'($urandom)
								: id_pool[$urandom_range(pool_n - 1)]);
					end
				end
			endcase
		end
	endtask

	// Request driver: offers queued requests and predicts each accepted one.
	always @(posedge clk or negedge arst_n) begin : drv
		request_t r;
		bit       offer;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd      <= '0;
			all_ids  <= 1'b0;
			proc_id  <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				r.cmd     = cmd_t'(cmd);
				r.all_ids = all_ids;
				r.proc_id = proc_id;
				verdict_q.push_back(trace_verdict(r));
				n_accepted++;
			end
			if (!in_valid || !in_stall) begin
				offer = request_q.size() > 0 && !hold_in &&
					$urandom_range(99) >= idle_pct;
				if (offer) begin
					r = request_q.pop_front();
					in_valid <= 1'b1;
					cmd      <= r.cmd;
					all_ids  <= r.all_ids;
					proc_id  <= r.proc_id;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: random back-pressure and field-by-field comparison.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= $urandom_range(99) < stall_pct;
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					n_bad++;
					if (n_bad <= 10) begin
						$display("ERROR: unexpected response status=%0d traced=%0b",
							status, traced);
					end
				end else begin
					got = verdict_q.pop_front();
					if (status !== got.status || traced !== got.traced) begin
						n_bad++;
						if (n_bad <= 10) begin
							$display({"ERROR: response mismatch: ",
								"status exp %0d got %0d, traced exp %0b got %0b"},
								got.status, status, got.traced, traced);
						end
					end
				end
			end
		end
	end

	// Main sequence: reset, traffic phases, one full drain, then the verdict.
	initial begin
		build_requests();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (request_q.size() > 0 || in_valid) begin
			@(negedge clk);
			case ((n_accepted / 160) % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 52; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 52; end
				default: begin idle_pct = 33; stall_pct = 33; end
			endcase
			// Once, let the DUT drain completely before offering more requests.
			if (!drained && n_accepted >= 700) begin
				hold_in = 1'b1;
				while (in_valid || verdict_q.size() > 0) begin
					@(negedge clk);
				end
				hold_in = 1'b0;
				drained = 1'b1;
			end
		end
		while (verdict_q.size() > 0) begin
			@(negedge clk);
		end
		repeat (20) @(negedge clk);
		if (n_bad == 0 && verdict_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/ptf_pkg.sv
rtl/core/ptf_ctrl.sv
rtl/core/ptf_dpath.sv
rtl/core/pid_trace_filter_table.sv
bench/tb_top.sv
